// ----- sv/multi_lfo_modulation_bank_top_defines.svh -----
// ============================================================================
// multi_lfo_modulation_bank_top_defines.svh
// Assertion macros shared by the LFO bank top level.
// ============================================================================
`ifndef MULTI_LFO_MODULATION_BANK_TOP_DEFINES_SVH
`define MULTI_LFO_MODULATION_BANK_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLFO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLFO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mlfo_pkg.sv -----
// ============================================================================
// mlfo_pkg
// Types, field layout, command codes and tables of the LFO bank.
// ============================================================================
package mlfo_pkg;

    localparam int WORD_W    = 48;
    localparam int RATE_W    = 24;
    localparam int DEPTH_W   = 16;
    localparam int TGT_W     = 5;
    localparam int WAVE_W    = 3;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 2;
    localparam int DT_W      = 24;
    localparam int OFS_W     = 20;
    localparam int VAL_W     = 17;
    localparam int HR_W      = 17;
    localparam int SUM_W     = 52;
    localparam int PHASE_W   = 32;
    localparam int RNG_W     = 64;
    localparam int HELD_W    = 16;
    localparam int CELL_NUM_W = 5;

    localparam int RATE_LSB  = 0;
    localparam int DEPTH_LSB = 24;
    localparam int TGT_LSB   = 40;
    localparam int WAVE_LSB  = 45;

    localparam int REG_IDX_W    = 3;
    localparam int PADDR_W      = 6;
    localparam int PDATA_W      = 64;
    localparam int WORD_REG_MAX = 4;

    localparam logic [REG_IDX_W-1:0] REG_BANK_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LFO0_WORD   = 3'd1;

    localparam logic [63:0] SEED_STEP   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    localparam logic signed [OFS_W-1:0] OFS_MAX = 20'sd262144;
    localparam logic signed [OFS_W-1:0] OFS_MIN = -20'sd262144;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_QUERY     = 3'd1,
        CMD_RESET_ALL = 3'd2,
        CMD_RESTART   = 3'd3,
        CMD_ARM       = 3'd4,
        CMD_RELEASE   = 3'd5
    } cmd_t;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE      = 3'd0,
        WAVE_TRIANGLE  = 3'd1,
        WAVE_SQUARE    = 3'd2,
        WAVE_SAW_UP    = 3'd3,
        WAVE_SAW_DOWN  = 3'd4,
        WAVE_RANDOM    = 3'd5
    } wave_t;

    // Item as it walks the cell chain, with the running query sum.
    typedef struct packed {
        logic                    valid;
        cmd_t                    cmd;
        logic                    live;
        logic [IDX_W-1:0]        lfo_index;
        logic [DT_W-1:0]         time_step;
        logic [TGT_W-1:0]        query_target;
        logic signed [SUM_W-1:0] sum;
    } item_t;

    // Side effects of a configuration word write on one cell.
    typedef struct packed {
        logic clear_phase;
        logic draw;
    } cfg_evt_t;

    function automatic logic [RNG_W-1:0] xorshift64(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    // Half range per target, unsigned Q2.15.
    function automatic logic [HR_W-1:0] half_range(input logic [TGT_W-1:0] tgt);
        logic [HR_W-1:0] hr;
        case (tgt) inside
            [5'd1:5'd4]:                       hr = 17'd65536;
            5'd6, 5'd7, 5'd16:                 hr = 17'd32768;
            5'd9:                              hr = 17'd9830;
            5'd5, 5'd8, [5'd10:5'd15], 5'd17:  hr = 17'd16384;
            default:                           hr = '0;
        endcase
        return hr;
    endfunction

    // Quarter-wave sine entry by an eleventh-order series in Q2.30; used only to
    // build the constant table at elaboration.
    function automatic logic [HELD_W-1:0] quarter_sine(input int unsigned k,
                                                       input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(k) * HALF_PI_Q30) >> (tb - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[HELD_W-1:0];
    endfunction

endpackage

// ----- sv/multi_lfo_modulation_bank_top.sv -----
// ============================================================================
// multi_lfo_modulation_bank_top
// Bank of LFOs with sample-and-hold noise, built as a chain of LFO cells.
// ============================================================================
//  channel   handshake                 payload
//  in        in_valid / in_stall       cmd, lfo_index, time_step, query_target
//  out       out_valid / out_stall     offset
//  config    APB (psel/penable/...)    bank_enable, lfo0..3 words at 8*(i+1)
//
// An item passes the head register, then the s1, s2 and output registers of each
// cell, and then the output register, where out_valid rises. The next item is
// not taken until the previous one has left the last cell, so items never overlap.
// Reset is asynchronous, active low; generators come up at their fixed seeds.
// A stalled result sits in the output register and holds the input stalled.
// ============================================================================
`include "multi_lfo_modulation_bank_top_defines.svh"

module multi_lfo_modulation_bank_top #(
    parameter int LFO_COUNT       = 4,
    parameter int TARGET_COUNT    = 17,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mlfo_pkg::CMD_W-1:0]      cmd,
    input  logic [mlfo_pkg::IDX_W-1:0]      lfo_index,
    input  logic [mlfo_pkg::DT_W-1:0]       time_step,
    input  logic [mlfo_pkg::TGT_W-1:0]      query_target,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [mlfo_pkg::OFS_W-1:0] offset,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlfo_pkg::PADDR_W-1:0]    paddr,
    input  logic [mlfo_pkg::PDATA_W-1:0]    pwdata,
    output logic [mlfo_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import mlfo_pkg::*;

    localparam int WORD_REGS = (LFO_COUNT < WORD_REG_MAX) ? LFO_COUNT : WORD_REG_MAX;

    logic                  bank_en_reg;
    logic [WORD_W-1:0]     lfo_word_reg [WORD_REGS];
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [OFS_W-1:0] offset_reg, offset_next;
    item_t                 head_reg, head_next;

    item_t    link    [LFO_COUNT+1];
    cfg_evt_t cfg_evt [LFO_COUNT];

    logic                  wr;
    logic [REG_IDX_W-1:0]  widx;
    logic                  accept;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign widx     = paddr[PADDR_W-1 -: REG_IDX_W];
    assign in_stall = busy_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign offset    = offset_reg;

    // Register read.
    always_comb
    begin
        prdata = '0;
        if (widx == REG_BANK_ENABLE)
        begin
            prdata = {{(PDATA_W-1){1'b0}}, bank_en_reg};
        end
        for (int i = 0; i < WORD_REGS; i++)
        begin
            if (widx == REG_IDX_W'(int'(REG_LFO0_WORD) + i))
            begin
                prdata = {{(PDATA_W-WORD_W){1'b0}}, lfo_word_reg[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_en_reg <= 1'b0;
        end
        else if (wr && widx == REG_BANK_ENABLE)
        begin
            bank_en_reg <= pwdata[0];
        end
    end

    for (genvar g = 0; g < LFO_COUNT; g++)
    begin : g_lfo
        logic [WORD_W-1:0] word;
        if (g < WORD_REGS)
        begin : g_reg
            logic              hit;
            logic [WORD_W-1:0] new_word;
            logic              changed;
            assign hit      = wr && (widx == REG_IDX_W'(int'(REG_LFO0_WORD) + g));
            assign new_word = pwdata[WORD_W-1:0];
            assign changed  =
                (new_word[TGT_LSB +: TGT_W] != lfo_word_reg[g][TGT_LSB +: TGT_W]) ||
                (new_word[WAVE_LSB +: WAVE_W] != lfo_word_reg[g][WAVE_LSB +: WAVE_W]);
            assign cfg_evt[g].clear_phase = hit && changed;
            assign cfg_evt[g].draw        = hit && changed &&
                (wave_t'(new_word[WAVE_LSB +: WAVE_W]) == WAVE_RANDOM);
            assign word = lfo_word_reg[g];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lfo_word_reg[g] <= '0;
                end
                else if (hit)
                begin
                    lfo_word_reg[g] <= new_word;
                end
            end
        end
        else
        begin : g_idle
            assign cfg_evt[g] = '0;
            assign word       = '0;
        end

        mlfo_cell #(
            .CELL_ID         (g),
            .SINE_TABLE_BITS (SINE_TABLE_BITS),
            .SEED            (SEED_STEP * 64'(g + 1))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word     (word),
            .cfg_evt  (cfg_evt[g]),
            .item_in  (link[g]),
            .item_out (link[g+1])
        );
    end

    assign link[0] = head_reg;

    // Chain head: load an accepted item.
    always_comb
    begin
        head_next              = '0;
        head_next.valid        = accept;
        head_next.cmd          = cmd_t'(cmd);
        head_next.lfo_index    = lfo_index;
        head_next.time_step    = time_step;
        head_next.query_target = query_target;
        case (cmd_t'(cmd))
            CMD_TICK:  head_next.live = bank_en_reg;
            CMD_QUERY: head_next.live = bank_en_reg && (query_target != '0) &&
                                        (query_target <= TGT_W'(TARGET_COUNT));
            default:   head_next.live = 1'b0;
        endcase
    end

    // Round half-up to Q.15 and saturate; items other than a live query give zero.
    item_t                      tail;
    logic signed [SUM_W-1:0]    rounded;
    logic signed [SUM_W-31:0]   scaled;

    assign tail = link[LFO_COUNT];

    always_comb
    begin
        rounded = tail.sum + (SUM_W'(1) <<< 29);
        scaled  = rounded[SUM_W-1:30];
        if (!(tail.cmd == CMD_QUERY && tail.live))
        begin
            offset_next = '0;
        end
        else if (scaled > (SUM_W-30)'(OFS_MAX))
        begin
            offset_next = OFS_MAX;
        end
        else if (scaled < (SUM_W-30)'(OFS_MIN))
        begin
            offset_next = OFS_MIN;
        end
        else
        begin
            offset_next = scaled[OFS_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (tail.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            offset_reg <= offset_next;
        end
    end

    `MLFO_ASSERT_NEXT(a_accept_sets_busy, accept, busy_reg, "accepted item did not mark busy")
    `MLFO_ASSERT_SAME(a_tail_in_flight, tail.valid, busy_reg, "result without an item in flight")
    `MLFO_ASSERT_SAME(a_tail_slot_free, tail.valid, !(out_valid_reg && out_stall),
                      "result would overwrite a stalled result")

endmodule

// ----- sv/mlfo_cell.sv -----
// ============================================================================
// mlfo_cell
// One LFO of the bank: holds its phase, generator and held sample, acts on
// the item passing through and hands the item to the next cell.
// ============================================================================
module mlfo_cell #(
    parameter int          CELL_ID         = 0,
    parameter int          SINE_TABLE_BITS = 8,
    parameter logic [63:0] SEED            = 64'h9E37_79B9_7F4A_7C15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mlfo_pkg::WORD_W-1:0] word,
    input  mlfo_pkg::cfg_evt_t        cfg_evt,
    input  mlfo_pkg::item_t           item_in,
    output mlfo_pkg::item_t           item_out
);
    import mlfo_pkg::*;

    localparam int QTR = 1 << (SINE_TABLE_BITS - 2);
    localparam int KW  = SINE_TABLE_BITS - 1;
    localparam logic [CELL_NUM_W-1:0] CELL_NUM = CELL_NUM_W'(CELL_ID);

    logic [HELD_W-1:0] sine_rom [QTR+1];

    for (genvar k = 0; k <= QTR; k++)
    begin : g_rom
        localparam logic [HELD_W-1:0] ENTRY = quarter_sine(k, SINE_TABLE_BITS);
        assign sine_rom[k] = ENTRY;
    end

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RNG_W-1:0]   rng_reg, rng_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic               arm_reg, arm_next;

    item_t                   s1_item_reg, s2_item_reg, out_item_reg, out_item_next;
    logic signed [49:0]      s1_prod_reg;
    logic signed [SUM_W-1:0] s2_term_reg, s2_term_next;

    logic [RATE_W-1:0]        rate;
    logic signed [DEPTH_W-1:0] depth;
    logic [TGT_W-1:0]         target;
    wave_t                    wave;
    logic                     lfo_on;

    assign rate   = word[RATE_LSB +: RATE_W];
    assign depth  = $signed(word[DEPTH_LSB +: DEPTH_W]);
    assign target = word[TGT_LSB +: TGT_W];
    assign wave   = wave_t'(word[WAVE_LSB +: WAVE_W]);
    assign lfo_on = (target != '0) && (depth != '0) && !arm_reg;

    // Waveform value from the current phase.
    logic [SINE_TABLE_BITS-1:0] sidx;
    logic [1:0]                 quad;
    logic [KW-1:0]              kk;
    logic signed [VAL_W-1:0]    sine_mag, wave_val;
    logic signed [VAL_W:0]      tri_w, saw_w;

    always_comb
    begin
        sidx     = phase_reg[PHASE_W-1 -: SINE_TABLE_BITS];
        quad     = sidx[SINE_TABLE_BITS-1 -: 2];
        kk       = quad[0] ? (KW'(QTR) - {1'b0, sidx[SINE_TABLE_BITS-3:0]})
                           : {1'b0, sidx[SINE_TABLE_BITS-3:0]};
        sine_mag = $signed({1'b0, sine_rom[kk]});
        tri_w    = '0;
        saw_w    = '0;
        case (wave)
            WAVE_TRIANGLE:
            begin
                if (phase_reg[31:30] == 2'b00)
                begin
                    tri_w = $signed({1'b0, phase_reg[31:15]});
                end
                else if (phase_reg[31:30] == 2'b11)
                begin
                    tri_w = $signed({1'b0, phase_reg[31:15]}) - 18'sd131072;
                end
                else
                begin
                    tri_w = 18'sd65536 - $signed({1'b0, phase_reg[31:15]});
                end
                wave_val = tri_w[VAL_W-1:0];
            end
            WAVE_SQUARE:
            begin
                wave_val = phase_reg[31] ? -17'sd32768 : 17'sd32768;
            end
            WAVE_SAW_UP:
            begin
                saw_w    = $signed({2'b00, phase_reg[31:16]}) - 18'sd32768;
                wave_val = saw_w[VAL_W-1:0];
            end
            WAVE_SAW_DOWN:
            begin
                saw_w    = 18'sd32768 - $signed({2'b00, phase_reg[31:16]});
                wave_val = saw_w[VAL_W-1:0];
            end
            WAVE_RANDOM:
            begin
                wave_val = $signed({held_reg[HELD_W-1], held_reg});
            end
            default:
            begin
                wave_val = quad[1] ? -sine_mag : sine_mag;
            end
        endcase
    end

    // Stage 1 multiply: rate * dt on a tick, value * depth otherwise.
    logic signed [24:0] op_a, op_b;
    logic signed [49:0] prod;

    always_comb
    begin
        if (item_in.cmd == CMD_TICK)
        begin
            op_a = $signed({1'b0, rate});
            op_b = $signed({1'b0, item_in.time_step});
        end
        else
        begin
            op_a = {{8{wave_val[VAL_W-1]}}, wave_val};
            op_b = {{9{depth[DEPTH_W-1]}}, depth};
        end
        prod = op_a * op_b;
    end

    // Stage 2: scale by half range, apply state changes.
    logic [HR_W-1:0]          hr;
    logic signed [50:0]       term_full;
    logic [40:0]              phase_sum;
    logic                     mine, do_draw;
    logic [RNG_W-1:0]         rng_drawn;

    always_comb
    begin
        hr        = half_range(s1_item_reg.query_target);
        term_full = $signed(s1_prod_reg[32:0]) * $signed({1'b0, hr});
        if (s1_item_reg.valid && s1_item_reg.cmd == CMD_QUERY && s1_item_reg.live
            && lfo_on && target == s1_item_reg.query_target)
        begin
            s2_term_next = {term_full[50], term_full};
        end
        else
        begin
            s2_term_next = '0;
        end
    end

    always_comb
    begin
        phase_sum  = {9'b0, phase_reg} + {1'b0, s1_prod_reg[47:8]};
        mine       = ({3'b0, s1_item_reg.lfo_index} == CELL_NUM);
        rng_drawn  = xorshift64(rng_reg);
        phase_next = phase_reg;
        arm_next   = arm_reg;
        do_draw    = 1'b0;
        if (s1_item_reg.valid)
        begin
            case (s1_item_reg.cmd)
                CMD_TICK:
                begin
                    if (s1_item_reg.live && lfo_on)
                    begin
                        phase_next = phase_sum[PHASE_W-1:0];
                        do_draw    = (|phase_sum[40:32]) && (wave == WAVE_RANDOM);
                    end
                end
                CMD_RESET_ALL:
                begin
                    phase_next = '0;
                    do_draw    = 1'b1;
                end
                CMD_RESTART:
                begin
                    if (mine)
                    begin
                        phase_next = '0;
                        do_draw    = (wave == WAVE_RANDOM);
                    end
                end
                CMD_ARM:
                begin
                    if (mine)
                    begin
                        arm_next   = 1'b1;
                        phase_next = '0;
                    end
                end
                CMD_RELEASE:
                begin
                    if (mine)
                    begin
                        arm_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (cfg_evt.clear_phase)
            begin
                phase_next = '0;
            end
            do_draw = cfg_evt.draw;
        end
        rng_next  = do_draw ? rng_drawn : rng_reg;
        held_next = do_draw ? rng_drawn[RNG_W-1 -: HELD_W] : held_reg;
    end

    // add this cell's term to the running sum
    always_comb
    begin
        out_item_next     = s2_item_reg;
        out_item_next.sum = s2_item_reg.sum + s2_term_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            rng_reg      <= SEED;
            held_reg     <= '0;
            arm_reg      <= 1'b0;
            s1_item_reg  <= '0;
            s2_item_reg  <= '0;
            out_item_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            rng_reg      <= rng_next;
            held_reg     <= held_next;
            arm_reg      <= arm_next;
            s1_item_reg  <= item_in;
            s2_item_reg  <= s1_item_reg;
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= prod;
        s2_term_reg <= s2_term_next;
    end

    assign item_out = out_item_reg;

endmodule

// ----- sim/tb_multi_lfo_modulation_bank_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFO bank testbench
// Drives command items through the bank under random input gaps and output
// stalls, writes the enable and LFO words over APB between phases, and checks
// every offset against a cycle-free model of phases, generators and sums.
// ----------------------------------------------------------------------------
module tb_multi_lfo_modulation_bank_top;
    import mlfo_pkg::*;

    localparam int NLFO = 4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] lfo_index;
        logic [DT_W-1:0]  time_step;
        logic [TGT_W-1:0] query_target;
    } cmd_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CMD_W-1:0] cmd = '0;
    logic [IDX_W-1:0] lfo_index = '0;
    logic [DT_W-1:0] time_step = '0;
    logic [TGT_W-1:0] query_target = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OFS_W-1:0] offset;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    multi_lfo_modulation_bank_top dut (.*);

    always #10 clk = ~clk;

    // model state
    logic [31:0] phase_q [NLFO];
    logic [63:0] rng_q [NLFO];
    logic [15:0] held_q [NLFO];
    logic armed_q [NLFO];
    logic [47:0] word_q [NLFO];
    logic enable_q;
    logic [15:0] sine_rom [65];

    cmd_item_t pending_items[$];
    logic signed [OFS_W-1:0] expected_offsets[$];
    int errors = 0;
    int accepted = 0;
    int total_items = 0;
    logic in_taken = 1'b0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    function automatic logic [63:0] next_rng(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    function automatic void draw_sample(input int i);
        rng_q[i] = next_rng(rng_q[i]);
        held_q[i] = rng_q[i][63:48];
    endfunction

    function automatic logic [15:0] sine_entry(input longint unsigned k);
        longint unsigned x, x2, t, s, one;
        one = 64'd1 << 30;
        x = (k * 64'd1686629713) >> 6;
        x2 = (x * x) >> 30;
        t = one - x2 / 110;
        t = one - ((x2 * t) >> 30) / 72;
        t = one - ((x2 * t) >> 30) / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        s = (s + 16384) >> 15;
        if (s > 32768) s = 32768;
        return s[15:0];
    endfunction

    function automatic longint wave_of(input int i);
        longint p, v;
        int idx, quad, k;
        p = longint'(phase_q[i]);
        case (word_q[i][47:45])
            WAVE_TRIANGLE:
                if (p < 64'h4000_0000) return p >>> 15;
                else if (p < 64'hC000_0000) return 65536 - (p >>> 15);
                else return (p >>> 15) - 131072;
            WAVE_SQUARE: return p < 64'h8000_0000 ? 32768 : -32768;
            WAVE_SAW_UP: return (p >>> 16) - 32768;
            WAVE_SAW_DOWN: return 32768 - (p >>> 16);
            WAVE_RANDOM: return longint'($signed(held_q[i]));
            default:
            begin
                idx = int'(phase_q[i][31:24]);
                quad = idx >> 6;
                k = idx & 63;
                v = (quad & 1) ? sine_rom[64 - k] : sine_rom[k];
                return (quad & 2) ? -v : v;
            end
        endcase
    endfunction

    function automatic longint range_of(input int tgt);
        case (tgt)
            1, 2, 3, 4: return 65536;
            6, 7, 16: return 32768;
            9: return 9830;
            5, 8, 10, 11, 12, 13, 14, 15, 17: return 16384;
            default: return 0;
        endcase
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NLFO; i++)
        begin
            phase_q[i] = '0;
            rng_q[i] = SEED_STEP * 64'(i + 1);
            held_q[i] = '0;
            armed_q[i] = 1'b0;
            word_q[i] = '0;
        end
        enable_q = 1'b0;
    endfunction

    function automatic void apply_config(input int reg_idx, input logic [63:0] value);
        logic [47:0] w;
        int i;
        if (reg_idx == 0)
        begin
            enable_q = value[0];
            return;
        end
        i = reg_idx - 1;
        w = value[47:0];
        if (w[44:40] != word_q[i][44:40] || w[47:45] != word_q[i][47:45])
        begin
            word_q[i] = w;
            phase_q[i] = '0;
            if (w[47:45] == WAVE_RANDOM) draw_sample(i);
        end
        word_q[i] = w;
    endfunction

    function automatic logic signed [OFS_W-1:0] predict_offset(input cmd_item_t it);
        longint acc, r, d, hr;
        logic [40:0] sum;
        int li;
        li = int'(it.lfo_index);
        r = 0;
        case (it.cmd)
            CMD_TICK:
                if (enable_q)
                    for (int i = 0; i < NLFO; i++)
                    begin
                        if (word_q[i][44:40] == 0 || word_q[i][39:24] == 0 || armed_q[i])
                            continue;
                        sum = 41'(phase_q[i]) +
                              41'((64'(word_q[i][23:0]) * 64'(it.time_step)) >> 8);
                        phase_q[i] = sum[31:0];
                        if ((|sum[40:32]) && word_q[i][47:45] == WAVE_RANDOM) draw_sample(i);
                    end
            CMD_QUERY:
                if (enable_q && it.query_target != 0 && it.query_target <= 17)
                begin
                    acc = 0;
                    hr = range_of(int'(it.query_target));
                    for (int i = 0; i < NLFO; i++)
                    begin
                        d = longint'($signed(word_q[i][39:24]));
                        if (armed_q[i] || word_q[i][44:40] != it.query_target || d == 0)
                            continue;
                        acc += wave_of(i) * d * hr;
                    end
                    r = (acc + (64'sd1 << 29)) >>> 30;
                    if (r > 262144) r = 262144;
                    if (r < -262144) r = -262144;
                end
            CMD_RESET_ALL:
                for (int i = 0; i < NLFO; i++)
                begin
                    phase_q[i] = '0;
                    draw_sample(i);
                end
            CMD_RESTART:
            begin
                phase_q[li] = '0;
                if (word_q[li][47:45] == WAVE_RANDOM) draw_sample(li);
            end
            CMD_ARM:
            begin
                armed_q[li] = 1'b1;
                phase_q[li] = '0;
            end
            CMD_RELEASE: armed_q[li] = 1'b0;
            default: ;
        endcase
        return r[OFS_W-1:0];
    endfunction

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 40) return 0;
        if (g < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // note whether the item on the bus was taken at this edge
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    // driver
    int in_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_valid)
            begin
                in_gap = gap_len();
            end
            if (in_gap > 0 || pending_items.size() == 0)
            begin
                if (in_gap > 0) in_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                cmd_item_t it;
                it = pending_items.pop_front();
                cmd <= it.cmd;
                lfo_index <= it.lfo_index;
                time_step <= it.time_step;
                query_target <= it.query_target;
                in_valid <= 1'b1;
            end
        end
    end

    // output stall
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = gap_len();
                out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                cmd_item_t it;
                it.cmd = cmd;
                it.lfo_index = lfo_index;
                it.time_step = time_step;
                it.query_target = query_target;
                expected_offsets.push_back(predict_offset(it));
                accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_offsets.size() == 0)
                    report($sformatf("offset %0d with nothing expected", offset));
                else
                begin
                    logic signed [OFS_W-1:0] want;
                    want = expected_offsets.pop_front();
                    if (offset !== want)
                        report($sformatf("offset %0d, want %0d", offset, want));
                end
            end
        end
    end

    task automatic write_reg(input int reg_idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(8 * reg_idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        apply_config(reg_idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_item(input logic [CMD_W-1:0] c, input int li,
                             input logic [DT_W-1:0] dt, input int tgt);
        cmd_item_t it;
        it.cmd = c;
        it.lfo_index = IDX_W'(li);
        it.time_step = dt;
        it.query_target = TGT_W'(tgt);
        pending_items.push_back(it);
        total_items++;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || accepted != total_items ||
               expected_offsets.size() != 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_word(input int mode);
        logic [47:0] w;
        w = 48'({$urandom, $urandom});
        if (mode == 1) w[44:40] = 5'($urandom_range(1, 17));
        if (mode == 1 && $urandom_range(0, 3) != 0) w[44:40] = 5'($urandom_range(1, 3));
        if (mode == 1) w[47:45] = 3'($urandom_range(0, 5));
        if (mode == 1 && $urandom_range(0, 2) == 0) w[23:0] = 24'($urandom_range(0, 4095) << 12);
        return w;
    endfunction

    function automatic int rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_TICK;
        if (r < 85) return CMD_QUERY;
        if (r < 89) return CMD_RESET_ALL;
        if (r < 93) return CMD_RESTART;
        if (r < 96) return CMD_ARM;
        if (r < 99) return CMD_RELEASE;
        return $urandom_range(6, 7);
    endfunction

    initial
    begin
        for (int k = 0; k <= 64; k++) sine_rom[k] = sine_entry(k);
        reset_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled bank: nothing moves, queries answer zero
        write_reg(1, 64'({WAVE_SQUARE, 5'd1, 16'h7FFF, 24'hFFFFFF}));
        push_item(CMD_TICK, 0, 24'hFFFFFF, 0);
        push_item(CMD_QUERY, 0, 0, 1);
        drain();

        // extremes: full depth, max rate, three LFOs on target one, saturation
        write_reg(0, 64'd1);
        write_reg(2, 64'({WAVE_SQUARE, 5'd1, 16'h7FFF, 24'h000000}));
        write_reg(3, 64'({WAVE_SAW_DOWN, 5'd1, 16'h8000, 24'hFFFFFF}));
        write_reg(4, 64'({WAVE_RANDOM, 5'd17, 16'h8000, 24'h010000}));
        push_item(CMD_QUERY, 0, 0, 1);
        push_item(CMD_QUERY, 0, 0, 0);
        push_item(CMD_QUERY, 0, 0, 18);
        push_item(CMD_QUERY, 0, 0, 31);
        push_item(CMD_QUERY, 0, 0, 17);
        push_item(CMD_TICK, 0, 24'hFFFFFF, 0);
        push_item(CMD_QUERY, 0, 0, 1);
        push_item(CMD_TICK, 0, 24'h000000, 0);
        push_item(CMD_ARM, 1, 0, 0);
        push_item(CMD_QUERY, 0, 0, 1);
        push_item(CMD_TICK, 0, 24'h800000, 0);
        push_item(CMD_RELEASE, 1, 0, 0);
        push_item(CMD_RESTART, 3, 0, 0);
        push_item(CMD_QUERY, 0, 0, 17);
        push_item(CMD_RESET_ALL, 0, 0, 0);
        push_item(CMD_QUERY, 0, 0, 17);
        push_item(3'd6, 2, 24'h123456, 5);
        push_item(3'd7, 3, 24'hABCDEF, 9);
        push_item(CMD_RELEASE, 3, 0, 0);
        drain();

        // random phases with fresh words
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(0, (ph % 4 == 3) ? 64'd0 : 64'd1);
            for (int r = 1; r <= 4; r++)
                if ($urandom_range(0, 2) != 0)
                    write_reg(r, {16'h0, rand_word($urandom_range(0, 5) == 0 ? 0 : 1)});
            if (ph == 9) write_reg(1, 64'hFFFF_FFFF_FFFF_FFFF);
            for (int n = 0; n < 75; n++)
                push_item(3'(rand_cmd()), $urandom_range(0, 3), 24'($urandom),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                    : int'(word_q[$urandom_range(0, 3)][44:40]));
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
